### rtl/mncf_pkg.sv
`default_nettype none

package mncf_pkg;

    localparam int SR_W       = 18;
    localparam int FRM_W      = 13;
    localparam int LEN_W      = 21;
    localparam int GAIN_W     = 17;
    localparam int SMP_W      = 24;
    localparam int FI_W       = 12;
    localparam int MS_W       = 14;
    localparam int NET_W      = 4;
    localparam int MODE_W     = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 18;
    localparam int DIVN_W     = 32;
    localparam int DIVD_W     = 21;
    localparam int PROD_W     = 44;
    localparam int MS_PER_S   = 1000;
    localparam int FRM_LIMIT  = 8191;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LENGTH = 1'd1;

    localparam logic [SR_W-1:0]   SR_RESET     = 18'd48000;
    localparam logic [FRM_W-1:0]  FRM_RESET    = 13'd64;
    localparam logic [GAIN_W-1:0] UNITY        = 17'h10000;
    localparam logic [LEN_W-1:0]  FADE_LEN_MAX = 21'h1FFFFF;

    typedef enum logic [MODE_W-1:0] {
        MODE_INACTIVE = 2'd0,
        MODE_ACTIVE   = 2'd1,
        MODE_FADE_IN  = 2'd2,
        MODE_FADE_OUT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        MUL_LEN,
        MUL_Q,
        MUL_P
    } t_mul_sel;

    typedef enum logic [1:0] {
        DIV_LEN,
        DIV_STEP,
        DIV_Q
    } t_div_sel;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DECODE,
        ST_XF_MUL,
        ST_XF_DIV,
        ST_XF_WAIT,
        ST_XF_WR0,
        ST_XF_WR1,
        ST_STEP_DIV,
        ST_STEP_WAIT,
        ST_EF,
        ST_Q_MUL,
        ST_Q_DIV,
        ST_Q_WAIT,
        ST_GAIN,
        ST_P_MUL,
        ST_P_ABS,
        ST_MIX,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic     load_in;
        logic     preset;
        logic     mul_en;
        t_mul_sel mul_sel;
        logic     div_start;
        t_div_sel div_sel;
        logic     xf_wr0;
        logic     xf_wr1;
        logic     ef_en;
        logic     gain_en;
        logic     abs_en;
        logic     mix_en;
        logic     load_out;
    } t_cmd;

    typedef struct packed {
        logic func;
        logic n_ok;
        logic fl_zero;
        logic div_busy;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

### rtl/mncf_in_if.sv
`default_nettype none

interface mncf_in_if;
    import mncf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     func;
    logic [NET_W-1:0]         net_index;
    logic [FI_W-1:0]          frame_index;
    logic signed [SMP_W-1:0]  sample;
    logic signed [SMP_W-1:0]  mix_in;
    logic                     block_last;
    logic [MS_W-1:0]          fade_ms;

    modport source (
        output valid, func, net_index, frame_index, sample, mix_in, block_last, fade_ms,
        input  ready
    );

    modport sink (
        input  valid, func, net_index, frame_index, sample, mix_in, block_last, fade_ms,
        output ready
    );
endinterface

`default_nettype wire

### rtl/mncf_out_if.sv
`default_nettype none

interface mncf_out_if;
    import mncf_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SMP_W-1:0]  mix_out;
    logic [GAIN_W-1:0]        gain_applied;
    logic [NET_W-1:0]         current_net;
    logic [MODE_W-1:0]        net_mode_out;

    modport source (
        output valid, mix_out, gain_applied, current_net, net_mode_out,
        input  ready
    );

    modport sink (
        input  valid, mix_out, gain_applied, current_net, net_mode_out,
        output ready
    );
endinterface

`default_nettype wire

### rtl/multi_network_crossfade_mixer_core.sv
`default_nettype none

// Mixes up to NETS audio networks into one 24-bit output through per-network Q16
// linear gain ramps, with a crossfade command that fades out the current network and
// fades in the next one. Each item is handled alone: a mix sample makes two passes
// through the shared 2-bit-per-cycle 32-bit divider (gain step, then interpolation)
// plus the shared multiplier; a sample whose network has zero fade length skips the
// gain step pass, and a sample for a network index at or above NETS goes straight to
// its result. The core is ready for the next item in the cycle after a result is
// loaded. The result register lets the next item be taken while a finished result
// waits downstream; the core then holds its finished result until that register
// is free.
module multi_network_crossfade_mixer_core #(
    parameter int NETS      = 2,
    parameter int FRAME_MAX = 4096
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    mncf_in_if.sink                              i_in,
    mncf_out_if.source                           o_out,
    input  wire logic                            i_cfg_we,
    input  wire logic [mncf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [mncf_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import mncf_pkg::*;

    t_cmd    cmd;
    t_status st;
    logic    in_ready;
    logic    out_valid;
    logic signed [SMP_W-1:0] mix_out;
    logic [GAIN_W-1:0]       gain_applied;
    logic [NET_W-1:0]        current_net;
    logic [MODE_W-1:0]       net_mode_out;

    mncf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (in_ready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mncf_dpath #(
        .NETS      (NETS),
        .FRAME_MAX (FRAME_MAX)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_st           (st),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_func         (i_in.func),
        .i_net_index    (i_in.net_index),
        .i_frame_index  (i_in.frame_index),
        .i_sample       (i_in.sample),
        .i_mix_in       (i_in.mix_in),
        .i_block_last   (i_in.block_last),
        .i_fade_ms      (i_in.fade_ms),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (out_valid),
        .o_mix_out      (mix_out),
        .o_gain_applied (gain_applied),
        .o_current_net  (current_net),
        .o_net_mode_out (net_mode_out)
    );

    assign i_in.ready         = in_ready;
    assign o_out.valid        = out_valid;
    assign o_out.mix_out      = mix_out;
    assign o_out.gain_applied = gain_applied;
    assign o_out.current_net  = current_net;
    assign o_out.net_mode_out = net_mode_out;

endmodule

`default_nettype wire

### rtl/mncf_div.sv
`default_nettype none

module mncf_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mncf_pkg::DIVN_W-1:0] i_dividend,
    input  wire logic [mncf_pkg::DIVD_W-1:0] i_divisor,
    output logic                             o_busy,
    output logic                             o_done,
    output logic [mncf_pkg::DIVN_W-1:0]      o_quotient
);
    import mncf_pkg::*;

    localparam int STEPS = DIVN_W / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(STEPS - 1);

    logic [DIVD_W-1:0] r_rem, n_rem;
    logic [DIVN_W-1:0] r_work, n_work;
    logic [DIVD_W-1:0] r_dvs;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    always_comb begin
        logic [DIVD_W:0]   sh0, sh1;
        logic [DIVD_W-1:0] rem0;
        logic              q0, q1;
        sh0   = {r_rem, r_work[DIVN_W-1]};
        q0    = (sh0 >= {1'b0, r_dvs});
        rem0  = q0 ? DIVD_W'(sh0 - {1'b0, r_dvs}) : sh0[DIVD_W-1:0];
        sh1   = {rem0, r_work[DIVN_W-2]};
        q1    = (sh1 >= {1'b0, r_dvs});
        n_rem = q1 ? DIVD_W'(sh1 - {1'b0, r_dvs}) : sh1[DIVD_W-1:0];
        n_work = {r_work[DIVN_W-3:0], q0, q1};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_work <= i_dividend;
                r_dvs  <= i_divisor;
            end else if (r_busy) begin
                r_rem  <= n_rem;
                r_work <= n_work;
                r_cnt  <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_work;

endmodule

`default_nettype wire

### rtl/mncf_ctrl.sv
`default_nettype none

module mncf_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire mncf_pkg::t_status i_st,
    output mncf_pkg::t_cmd         o_cmd
);
    import mncf_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (i_st.func)         n_state = ST_XF_MUL;
                else if (!i_st.n_ok)   n_state = ST_DONE;
                else if (i_st.fl_zero) n_state = ST_EF;
                else                   n_state = ST_STEP_DIV;
            end
            ST_XF_MUL:    n_state = ST_XF_DIV;
            ST_XF_DIV:    n_state = ST_XF_WAIT;
            ST_XF_WAIT: begin
                if (i_st.div_done) n_state = ST_XF_WR0;
            end
            ST_XF_WR0:    n_state = ST_XF_WR1;
            ST_XF_WR1:    n_state = ST_DONE;
            ST_STEP_DIV:  n_state = ST_STEP_WAIT;
            ST_STEP_WAIT: begin
                if (i_st.div_done) n_state = ST_EF;
            end
            ST_EF:        n_state = ST_Q_MUL;
            ST_Q_MUL:     n_state = ST_Q_DIV;
            ST_Q_DIV:     n_state = ST_Q_WAIT;
            ST_Q_WAIT: begin
                if (i_st.div_done) n_state = ST_GAIN;
            end
            ST_GAIN:      n_state = ST_P_MUL;
            ST_P_MUL:     n_state = ST_P_ABS;
            ST_P_ABS:     n_state = ST_MIX;
            ST_MIX:       n_state = ST_DONE;
            ST_DONE: begin
                if (i_st.out_free) n_state = ST_IDLE;
            end
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.mul_sel = MUL_LEN;
        o_cmd.div_sel = DIV_LEN;
        o_in_ready    = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready    = i_rst_n;
                o_cmd.load_in = i_in_valid && i_rst_n;
            end
            ST_DECODE:   o_cmd.preset = 1'b1;
            ST_XF_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_LEN;
            end
            ST_XF_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_LEN;
            end
            ST_XF_WR0:   o_cmd.xf_wr0 = 1'b1;
            ST_XF_WR1:   o_cmd.xf_wr1 = 1'b1;
            ST_STEP_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_STEP;
            end
            ST_EF:       o_cmd.ef_en = 1'b1;
            ST_Q_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_Q;
            end
            ST_Q_DIV: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_Q;
            end
            ST_GAIN:     o_cmd.gain_en = 1'b1;
            ST_P_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = MUL_P;
            end
            ST_P_ABS:    o_cmd.abs_en = 1'b1;
            ST_MIX:      o_cmd.mix_en = 1'b1;
            ST_DONE:     o_cmd.load_out = i_st.out_free;
            default: ;
        endcase
    end

    a_idle_div_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !i_st.div_busy)
        else $error("divider busy while idle");

endmodule

`default_nettype wire

### rtl/mncf_dpath.sv
`default_nettype none

module mncf_dpath #(
    parameter int NETS      = 2,
    parameter int FRAME_MAX = 4096
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mncf_pkg::t_cmd                    i_cmd,
    output mncf_pkg::t_status                      o_st,
    input  wire logic                              i_cfg_we,
    input  wire logic [mncf_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [mncf_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_func,
    input  wire logic [mncf_pkg::NET_W-1:0]        i_net_index,
    input  wire logic [mncf_pkg::FI_W-1:0]         i_frame_index,
    input  wire logic signed [mncf_pkg::SMP_W-1:0] i_sample,
    input  wire logic signed [mncf_pkg::SMP_W-1:0] i_mix_in,
    input  wire logic                              i_block_last,
    input  wire logic [mncf_pkg::MS_W-1:0]         i_fade_ms,
    input  wire logic                              i_out_ready,
    output logic                                   o_out_valid,
    output logic signed [mncf_pkg::SMP_W-1:0]      o_mix_out,
    output logic [mncf_pkg::GAIN_W-1:0]            o_gain_applied,
    output logic [mncf_pkg::NET_W-1:0]             o_current_net,
    output logic [mncf_pkg::MODE_W-1:0]            o_net_mode_out
);
    import mncf_pkg::*;

    localparam int NIDX    = $clog2(NETS);
    localparam int FM_CLIP = (FRAME_MAX < FRM_LIMIT) ? FRAME_MAX : FRM_LIMIT;
    localparam logic signed [SMP_W+1:0] MIX_HI = 26'sd8388607;
    localparam logic signed [SMP_W+1:0] MIX_LO = -26'sd8388608;

    logic [SR_W-1:0]   r_sample_rate;
    logic [FRM_W-1:0]  r_frame_length;
    t_mode             r_net_mode     [NETS];
    logic [GAIN_W-1:0] r_net_gain     [NETS];
    logic [LEN_W-1:0]  r_net_fade_len [NETS];
    logic [NIDX-1:0]   r_cur;

    logic                    r_func;
    logic [NET_W-1:0]        r_n;
    logic [FI_W-1:0]         r_fi;
    logic signed [SMP_W-1:0] r_smp;
    logic signed [SMP_W-1:0] r_mix;
    logic                    r_last;
    logic [MS_W-1:0]         r_ms;

    logic signed [PROD_W-1:0] r_prod;
    logic [GAIN_W-1:0]        r_ef;
    logic                     r_dneg;
    logic [GAIN_W-1:0]        r_dabs;
    logic [FI_W-1:0]          r_fic;
    logic [GAIN_W-1:0]        r_g;
    logic [SMP_W-1:0]         r_pm;
    logic                     r_pneg;
    logic signed [SMP_W-1:0]  r_res_mix;
    logic [GAIN_W-1:0]        r_res_gain;
    t_mode                    r_res_mode;

    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_mix;
    logic [GAIN_W-1:0]       r_out_gain;
    logic [NET_W-1:0]        r_out_net;
    t_mode                   r_out_mode;

    logic                n_ok;
    logic [NIDX-1:0]     ni;
    logic [NIDX-1:0]     cur_next;
    t_mode               md;
    logic [GAIN_W-1:0]   bf;
    logic [LEN_W-1:0]    fl;
    logic [FRM_W-1:0]    frm_eff;
    logic                div_busy, div_done;
    logic [DIVN_W-1:0]   quot;
    logic [DIVN_W-1:0]   div_num;
    logic [DIVD_W-1:0]   div_den;
    logic [LEN_W-1:0]    len_sat;
    logic [GAIN_W-1:0]   step;
    logic signed [18:0]  ef_raw;
    logic [GAIN_W-1:0]   ef_c;
    logic signed [18:0]  d;
    logic [FI_W-1:0]     fic;
    logic signed [18:0]  g_raw;
    logic [GAIN_W-1:0]   g_c;
    logic [SR_W-1:0]     mul_a;
    logic signed [SMP_W:0] mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [PROD_W-1:0]   pabs;
    logic signed [SMP_W+1:0] sum;
    logic signed [SMP_W-1:0] mix_sat;
    t_mode               mode_new;
    logic                out_free;

    assign n_ok     = ({1'b0, r_n} < (NET_W + 1)'(NETS));
    assign ni       = r_n[NIDX-1:0];
    assign cur_next = (r_cur == NIDX'(NETS - 1)) ? '0 : r_cur + NIDX'(1);
    assign md       = r_net_mode[ni];
    assign bf       = r_net_gain[ni];
    assign fl       = r_net_fade_len[ni];

    always_comb begin
        if (r_frame_length == '0)                    frm_eff = FRM_W'(1);
        else if (r_frame_length > FRM_W'(FM_CLIP))   frm_eff = FRM_W'(FM_CLIP);
        else                                         frm_eff = r_frame_length;
    end

    always_comb begin
        case (i_cmd.div_sel)
            DIV_LEN: begin
                div_num = r_prod[DIVN_W-1:0];
                div_den = DIVD_W'(MS_PER_S);
            end
            DIV_STEP: begin
                div_num = DIVN_W'({frm_eff, 16'h0000}) + DIVN_W'(fl) - DIVN_W'(1);
                div_den = fl;
            end
            DIV_Q: begin
                div_num = r_prod[DIVN_W-1:0];
                div_den = DIVD_W'(frm_eff);
            end
            default: begin
                div_num = '0;
                div_den = DIVD_W'(1);
            end
        endcase
    end

    mncf_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    assign len_sat = (quot[DIVN_W-1:LEN_W] != '0) ? FADE_LEN_MAX : quot[LEN_W-1:0];

    always_comb begin
        if (fl == '0)                      step = UNITY;
        else if (quot > DIVN_W'(UNITY))    step = UNITY;
        else                               step = quot[GAIN_W-1:0];

        case (md)
            MODE_FADE_IN:  ef_raw = $signed({2'b00, bf}) + $signed({2'b00, step});
            MODE_FADE_OUT: ef_raw = $signed({2'b00, bf}) - $signed({2'b00, step});
            MODE_ACTIVE:   ef_raw = $signed({2'b00, UNITY});
            default:       ef_raw = '0;
        endcase

        if (ef_raw[18])                              ef_c = '0;
        else if (ef_raw > $signed({2'b00, UNITY}))   ef_c = UNITY;
        else                                         ef_c = ef_raw[GAIN_W-1:0];

        d   = $signed({2'b00, ef_c}) - $signed({2'b00, bf});
        fic = ({1'b0, r_fi} >= frm_eff) ? FI_W'(frm_eff - FRM_W'(1)) : r_fi;
    end

    always_comb begin
        if (r_dneg) g_raw = $signed({2'b00, bf}) - $signed({2'b00, quot[GAIN_W-1:0]});
        else        g_raw = $signed({2'b00, bf}) + $signed({2'b00, quot[GAIN_W-1:0]});
        if (g_raw[18])                              g_c = '0;
        else if (g_raw > $signed({2'b00, UNITY}))   g_c = UNITY;
        else                                        g_c = g_raw[GAIN_W-1:0];
    end

    always_comb begin
        case (i_cmd.mul_sel)
            MUL_LEN: begin
                mul_a = r_sample_rate;
                mul_b = $signed({11'b0, r_ms});
            end
            MUL_Q: begin
                mul_a = {1'b0, r_dabs};
                mul_b = $signed({13'b0, r_fic});
            end
            MUL_P: begin
                mul_a = {1'b0, r_g};
                mul_b = $signed({r_smp[SMP_W-1], r_smp});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod = $signed({1'b0, mul_a}) * mul_b;
    end

    assign pabs = r_prod[PROD_W-1] ? PROD_W'(-r_prod) : PROD_W'(r_prod);

    always_comb begin
        if (r_pneg) sum = $signed({{2{r_mix[SMP_W-1]}}, r_mix}) - $signed({2'b00, r_pm});
        else        sum = $signed({{2{r_mix[SMP_W-1]}}, r_mix}) + $signed({2'b00, r_pm});
        if (sum > MIX_HI)      mix_sat = MIX_HI[SMP_W-1:0];
        else if (sum < MIX_LO) mix_sat = MIX_LO[SMP_W-1:0];
        else                   mix_sat = sum[SMP_W-1:0];

        mode_new = md;
        if (r_last) begin
            if (md == MODE_FADE_IN && r_ef == UNITY)         mode_new = MODE_ACTIVE;
            else if (md == MODE_FADE_OUT && r_ef == '0)      mode_new = MODE_INACTIVE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_rate  <= SR_RESET;
            r_frame_length <= FRM_RESET;
            r_cur          <= '0;
            for (int k = 0; k < NETS; k++) begin
                r_net_mode[k]     <= (k == 0) ? MODE_ACTIVE : MODE_INACTIVE;
                r_net_gain[k]     <= '0;
                r_net_fade_len[k] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SAMPLE_RATE:  r_sample_rate  <= i_cfg_data[SR_W-1:0];
                    CFG_FRAME_LENGTH: r_frame_length <= i_cfg_data[FRM_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.xf_wr0) begin
                r_net_mode[r_cur]     <= MODE_FADE_OUT;
                r_net_fade_len[r_cur] <= len_sat;
            end
            if (i_cmd.xf_wr1) begin
                r_net_mode[cur_next]     <= MODE_FADE_IN;
                r_net_fade_len[cur_next] <= len_sat;
                r_cur                    <= cur_next;
            end
            if (i_cmd.mix_en && r_last) begin
                r_net_gain[ni] <= r_ef;
                r_net_mode[ni] <= mode_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_func <= i_func;
            r_n    <= i_net_index;
            r_fi   <= i_frame_index;
            r_smp  <= i_sample;
            r_mix  <= i_mix_in;
            r_last <= i_block_last;
            r_ms   <= i_fade_ms;
        end
        if (i_cmd.preset) begin
            r_res_mix  <= r_mix;
            r_res_gain <= '0;
            r_res_mode <= MODE_INACTIVE;
        end
        if (i_cmd.mul_en) r_prod <= prod;
        if (i_cmd.ef_en) begin
            r_ef   <= ef_c;
            r_dneg <= d[18];
            r_dabs <= d[18] ? GAIN_W'(-d) : d[GAIN_W-1:0];
            r_fic  <= fic;
        end
        if (i_cmd.gain_en) r_g <= g_c;
        if (i_cmd.abs_en) begin
            r_pneg <= r_prod[PROD_W-1];
            r_pm   <= pabs[39:16];
        end
        if (i_cmd.xf_wr1) begin
            if (!n_ok)              r_res_mode <= MODE_INACTIVE;
            else if (ni == cur_next) r_res_mode <= MODE_FADE_IN;
            else                    r_res_mode <= md;
        end
        if (i_cmd.mix_en) begin
            r_res_mix  <= mix_sat;
            r_res_gain <= r_g;
            r_res_mode <= mode_new;
        end
        if (i_cmd.load_out) begin
            r_out_mix  <= r_res_mix;
            r_out_gain <= r_res_gain;
            r_out_net  <= NET_W'(r_cur);
            r_out_mode <= r_res_mode;
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_st.func     = r_func;
    assign o_st.n_ok     = n_ok;
    assign o_st.fl_zero  = (fl == '0);
    assign o_st.div_busy = div_busy;
    assign o_st.div_done = div_done;
    assign o_st.out_free = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_mix_out      = r_out_mix;
    assign o_gain_applied = r_out_gain;
    assign o_current_net  = r_out_net;
    assign o_net_mode_out = r_out_mode;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before transfer");

    a_div_idle_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_gain_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.gain_en |=> (r_g <= UNITY))
        else $error("interpolated gain above unity");

endmodule

`default_nettype wire
